// ===== src/llrs_pkg.sv =====
package llrs_pkg;

   localparam int ROW_BITS      = 64;
   localparam int MAX_ROW_CELLS = 64;
   localparam int RULE_BITS     = 3;
   localparam int WIDTH_BITS    = 7;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 7;
   localparam int COUNT_BITS    = 4;
   localparam int RULE_MASK_BITS = 9;

   localparam logic [CSR_IDX_BITS-1:0] CSR_RULE_SELECT = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ROW_WIDTH   = 2'd1;

   localparam logic [RULE_BITS-1:0] RULE_LIFE       = 3'd0;
   localparam logic [RULE_BITS-1:0] RULE_HIGHLIFE   = 3'd1;
   localparam logic [RULE_BITS-1:0] RULE_PEDESTRIAN = 3'd2;
   localparam logic [RULE_BITS-1:0] RULE_GEOLOGY    = 3'd3;
   localparam logic [RULE_BITS-1:0] RULE_DIAMOEBA   = 3'd4;

   localparam logic [WIDTH_BITS-1:0] WIDTH_LIMIT = WIDTH_BITS'(MAX_ROW_CELLS);

   // one unit of work for the back end: a row window plus what to emit from it
   typedef struct packed {
      logic [ROW_BITS-1:0] above;
      logic [ROW_BITS-1:0] center;
      logic [ROW_BITS-1:0] row;
      logic                has_first;
      logic                last;
   } job_type;

   typedef struct packed {
      logic [RULE_MASK_BITS-1:0] birth;
      logic [RULE_MASK_BITS-1:0] survive;
   } rule_type;

   function automatic rule_type rule_lookup(input logic [RULE_BITS-1:0] sel);
      rule_type r;
      case (sel)
         RULE_LIFE:       r = '{birth: 9'h008, survive: 9'h00C};
         RULE_HIGHLIFE:   r = '{birth: 9'h048, survive: 9'h00C};
         RULE_PEDESTRIAN: r = '{birth: 9'h108, survive: 9'h00C};
         RULE_GEOLOGY:    r = '{birth: 9'h1A8, survive: 9'h1D4};
         RULE_DIAMOEBA:   r = '{birth: 9'h1E8, survive: 9'h1E0};
         default:         r = '{birth: 9'h000, survive: 9'h000};
      endcase
      return r;
   endfunction

   function automatic logic [ROW_BITS-1:0] active_mask(input logic [WIDTH_BITS-1:0] width);
      logic [WIDTH_BITS-1:0] w;
      logic [ROW_BITS-1:0]   m;
      w = (width > WIDTH_LIMIT) ? WIDTH_LIMIT : width;
      for (int i = 0; i < ROW_BITS; i++) begin
         m[i] = (WIDTH_BITS'(i) < w) && (i < MAX_ROW_CELLS);
      end
      return m;
   endfunction

   // one generation of the middle row, all cells side by side
   function automatic logic [ROW_BITS-1:0] next_row(
      input logic [ROW_BITS-1:0]   up,
      input logic [ROW_BITS-1:0]   mid,
      input logic [ROW_BITS-1:0]   down,
      input logic [RULE_BITS-1:0]  sel,
      input logic [WIDTH_BITS-1:0] width
   );
      logic [ROW_BITS-1:0]   m;
      logic [ROW_BITS+1:0]   pu;
      logic [ROW_BITS+1:0]   pm;
      logic [ROW_BITS+1:0]   pd;
      logic [COUNT_BITS-1:0] n;
      logic [ROW_BITS-1:0]   res;
      rule_type              r;
      m  = active_mask(width);
      r  = rule_lookup(sel);
      pu = {1'b0, up & m, 1'b0};
      pm = {1'b0, mid & m, 1'b0};
      pd = {1'b0, down & m, 1'b0};
      for (int i = 0; i < ROW_BITS; i++) begin
         n = COUNT_BITS'(pu[i]) + COUNT_BITS'(pu[i+1]) + COUNT_BITS'(pu[i+2])
           + COUNT_BITS'(pm[i]) + COUNT_BITS'(pm[i+2])
           + COUNT_BITS'(pd[i]) + COUNT_BITS'(pd[i+1]) + COUNT_BITS'(pd[i+2]);
         res[i] = pm[i+1] ? r.survive[n] : r.birth[n];
      end
      return res & m;
   endfunction

endpackage

// ===== src/llrs_front.sv =====
module llrs_front import llrs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [ROW_BITS-1:0]   req_row_cells,
   input  logic                  req_final_row,
   input  logic                  queue_full,
   input  logic [WIDTH_BITS-1:0] width,
   output logic                  req_stall,
   output logic                  push,
   output job_type               job
);

   logic [ROW_BITS-1:0] above_ff, above_in;
   logic [ROW_BITS-1:0] center_ff, center_in;
   logic                center_valid_ff, center_valid_in;
   logic [ROW_BITS-1:0] row;
   logic                accept;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign row       = req_row_cells & active_mask(width);

   // a first row that is not also the last gives nothing to compute yet
   assign push = accept && (center_valid_ff || req_final_row);

   always_comb begin
      job.above     = center_valid_ff ? above_ff  : '0;
      job.center    = center_valid_ff ? center_ff : '0;
      job.row       = row;
      job.has_first = center_valid_ff;
      job.last      = req_final_row;
   end

   always_comb begin
      above_in        = above_ff;
      center_in       = center_ff;
      center_valid_in = center_valid_ff;
      if (accept) begin
         above_in        = center_valid_ff ? center_ff : '0;
         center_in       = row;
         center_valid_in = 1'b1;
         if (req_final_row) begin
            above_in        = '0;
            center_in       = '0;
            center_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         above_ff        <= '0;
         center_ff       <= '0;
         center_valid_ff <= 1'b0;
      end else begin
         above_ff        <= above_in;
         center_ff       <= center_in;
         center_valid_ff <= center_valid_in;
      end
   end

endmodule

// ===== src/llrs_queue.sv =====
module llrs_queue import llrs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output logic    full,
   output logic    not_empty,
   output job_type head
);

   job_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== src/llrs_back.sv =====
module llrs_back import llrs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  job_valid,
   input  job_type               job,
   input  logic [RULE_BITS-1:0]  rule_select,
   input  logic [WIDTH_BITS-1:0] width,
   input  logic                  rsp_stall,
   output logic                  pop,
   output logic                  rsp_valid,
   output logic [ROW_BITS-1:0]   rsp_next_cells,
   output logic                  rsp_frame_end
);

   logic                phase_ff, phase_in;
   logic                valid_ff, valid_in;
   logic [ROW_BITS-1:0] cells_ff, cells_in;
   logic                end_ff, end_in;
   logic                fire;
   logic                bottom;
   logic [ROW_BITS-1:0] up, mid, down;

   assign fire   = job_valid && (!valid_ff || !rsp_stall);
   // bottom row of the frame: either the second pass or a lone final row
   assign bottom = phase_ff || !job.has_first;
   assign pop    = fire && (bottom || !job.last);

   always_comb begin
      if (bottom) begin
         up   = job.center;
         mid  = job.row;
         down = '0;
      end else begin
         up   = job.above;
         mid  = job.center;
         down = job.row;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      valid_in = valid_ff && rsp_stall;
      cells_in = cells_ff;
      end_in   = end_ff;
      if (fire) begin
         phase_in = !bottom && job.last;
         valid_in = 1'b1;
         cells_in = next_row(up, mid, down, rule_select, width);
         end_in   = bottom;
      end
   end

   always_ff @(posedge clock) begin
      cells_ff <= cells_in;
      end_ff   <= end_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_next_cells = cells_ff;
   assign rsp_frame_end  = end_ff;

endmodule

// ===== src/life_like_automaton_row_step.sv =====
// One generation of a two-state, life-like cellular automaton on a grid with
// a dead border, streamed one row per item. Send the grid top to bottom on
// req_, bit i of req_row_cells is cell i, and flag the bottom row with
// req_final_row. The first row of a frame gives no result; each later row
// gives the new generation of the row above it, and the bottom row gives one
// more, the new bottom row, marked by rsp_frame_end. A lone one-row grid
// gives a single result with rsp_frame_end set. Rate: one item per cycle in
// steady state while rsp_stall is low; the rule array evaluates all 64 cells
// side by side, and a bottom row that follows other rows occupies that unit
// twice, once per result. An accepted item passes through the two-entry job
// queue and the output register on its way to a result. Write csr_ index
// 0 (rule_select: 0 Life, 1 HighLife, 2 Pedestrian Life, 3 Geology,
// 4 Diamoeba, others give dead rows) and index 1 (row_width, saturates at 64)
// only while the block is idle; other indexes are dropped.
module life_like_automaton_row_step import llrs_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [ROW_BITS-1:0]      req_row_cells,
   input  logic                     req_final_row,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [ROW_BITS-1:0]      rsp_next_cells,
   output logic                     rsp_frame_end,
   input  logic                     csr_write,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   logic [RULE_BITS-1:0]  rule_ff, rule_in;
   logic [WIDTH_BITS-1:0] width_ff, width_in;

   logic    push;
   logic    pop;
   logic    queue_full;
   logic    queue_valid;
   job_type front_job;
   job_type head_job;

   // latch configuration writes; unknown indexes are dropped
   always_comb begin
      rule_in  = rule_ff;
      width_in = width_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_RULE_SELECT: rule_in  = csr_wdata[RULE_BITS-1:0];
            CSR_ROW_WIDTH:   width_in = csr_wdata[WIDTH_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rule_ff  <= RULE_LIFE;
         width_ff <= WIDTH_LIMIT;
      end else begin
         rule_ff  <= rule_in;
         width_ff <= width_in;
      end
   end

   // front: hold the row window and turn rows into jobs
   llrs_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_row_cells (req_row_cells),
      .req_final_row (req_final_row),
      .queue_full    (queue_full),
      .width         (width_ff),
      .req_stall     (req_stall),
      .push          (push),
      .job           (front_job)
   );

   // short queue: lets the front keep taking rows while a result waits
   llrs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (front_job),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_valid),
      .head      (head_job)
   );

   // back: apply the rule to all cells and register each result row
   llrs_back u_back (
      .clock          (clock),
      .reset          (reset),
      .job_valid      (queue_valid),
      .job            (head_job),
      .rule_select    (rule_ff),
      .width          (width_ff),
      .rsp_stall      (rsp_stall),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_next_cells (rsp_next_cells),
      .rsp_frame_end  (rsp_frame_end)
   );

endmodule
